// ===== sv/bmad_pkg.sv =====
// Shared constants, types and pixel arithmetic for the block mean absolute deviation unit.
package bmad_pkg;

   localparam int PIX_W            = 8;
   localparam int PIX_PER_WORD     = 8;
   localparam int WORD_W           = PIX_W * PIX_PER_WORD;
   localparam int ROW_PIX          = 2 * PIX_PER_WORD;
   localparam int MEAN_W           = 8;
   localparam int DEV_W            = 16;
   localparam int ROWS_CFG_W       = 5;
   localparam int ROWS_RESET       = 16;
   localparam int MAX_ROWS_DEFAULT = 16;
   localparam int REQ_DATA_W       = 2 * WORD_W;
   localparam int RSP_DATA_W       = MEAN_W + DEV_W;
   // sum of one word of pixels, and of one row of two words
   localparam int WSUM_W           = $clog2(PIX_PER_WORD * 255 + 1);
   localparam int RSUM_W           = WSUM_W + 1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Add up the eight pixels of one word.
   function automatic logic [WSUM_W-1:0] word_pixel_sum(input logic [WORD_W-1:0] w);
      logic [WSUM_W-1:0] s;
      s = '0;
      for (int i = 0; i < PIX_PER_WORD; i++) begin
         s = s + WSUM_W'(w[i*PIX_W +: PIX_W]);
      end
      return s;
   endfunction

   // Add up |pixel - mean| over the eight pixels of one word.
   function automatic logic [WSUM_W-1:0] word_deviation(input logic [WORD_W-1:0] w,
                                                        input logic [MEAN_W-1:0] mean);
      logic [WSUM_W-1:0] s;
      logic [PIX_W-1:0]  p;
      s = '0;
      for (int i = 0; i < PIX_PER_WORD; i++) begin
         p = w[i*PIX_W +: PIX_W];
         s = s + WSUM_W'((p >= mean) ? (p - mean) : (mean - p));
      end
      return s;
   endfunction

endpackage

// ===== sv/bmad_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bmad_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bmad_divider.sv =====
// Restoring divider that forms the 8-bit block mean, one quotient bit per cycle.
module bmad_divider #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]             den,
   output logic [bmad_pkg::MEAN_W-1:0]  quo,
   output bmad_pkg::div_status_type     status
);

   import bmad_pkg::*;

   localparam int SH_W   = DEN_W + MEAN_W - 1;
   localparam int CMP_W  = (NUM_W > SH_W) ? NUM_W : SH_W;
   localparam int STEP_W = (MEAN_W > 1) ? $clog2(MEAN_W) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  rem_ff,  rem_in;
   logic [SH_W-1:0]   dsh_ff,  dsh_in;
   logic [MEAN_W-1:0] quo_ff,  quo_in;
   logic              fits;

   // trial subtract of the shifted divisor
   assign fits = CMP_W'(rem_ff) >= CMP_W'(dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(MEAN_W - 1);
         rem_in  = num;
         dsh_in  = SH_W'(den) << (MEAN_W - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - NUM_W'(dsh_ff);
         end
         quo_in[step_ff] = fits;
         dsh_in          = dsh_ff >> 1;
         step_in         = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quo         = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sv/block_mean_abs_deviation_unit.sv =====
// Top level: row store, pixel totals, mean divider and deviation pass of a 16-wide block.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------------
//  req     | in  | req_tvalid/req_tready  | req_tdata: row_low, row_high
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: block_mean, deviation_sum
//  csr     | in  | csr_wen                | csr_wdata: block_rows
//
//  Rows are taken one per cycle while filling; both row words go into the two row RAMs
//  at once. After the last row of a block come a start state, the divider run and a
//  capture of the mean, then one RAM read per row through the read pipeline; no rows
//  are taken meanwhile, and rows of the next block follow once the result is raised.
//  Reset clears the state, counters, pipeline flags and result flag and sets the row count; the RAMs are not cleared.
//  A pending result does not block new rows, except the row that would end the block.
module block_mean_abs_deviation_unit #(
   parameter int MAX_ROWS = bmad_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] row_low, [127:64] row_high
   input  logic [bmad_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] block_mean, [23:8] deviation_sum
   output logic [bmad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wen,
   input  logic [bmad_pkg::ROWS_CFG_W-1:0]   csr_wdata
);

   import bmad_pkg::*;

   // largest row count: MAX_ROWS, but no more than the 5-bit register can ask for
   localparam int EFF_MAX = (MAX_ROWS < 31) ? MAX_ROWS : 31;
   localparam int ROWS_W  = $clog2(EFF_MAX + 1);
   localparam int ADDR_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int TOT_W   = $clog2(EFF_MAX * ROW_PIX * 255 + EFF_MAX * (ROW_PIX / 2) + 1);
   localparam int DIV_W   = ROWS_W + 4;
   localparam int SAT_W   = (TOT_W > DEV_W) ? TOT_W : DEV_W;

   localparam logic [2:0] S_FILL  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_PASS  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]            state_ff,      state_in;
   logic [ROWS_CFG_W-1:0] block_rows_ff, block_rows_in;
   logic [ROWS_W-1:0]     cnt_ff,        cnt_in;
   logic [TOT_W-1:0]      total_ff,      total_in;
   logic [ROWS_W-1:0]     rd_cnt_ff,     rd_cnt_in;
   logic                  v1_ff,         v1_in;
   logic                  last1_ff,      last1_in;
   logic                  v2_ff,         v2_in;
   logic                  last2_ff,      last2_in;
   logic [RSUM_W-1:0]     rowdev_ff,     rowdev_in;
   logic [TOT_W-1:0]      dev_acc_ff,    dev_acc_in;
   logic [MEAN_W-1:0]     mean_ff,       mean_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [MEAN_W-1:0]     rsp_mean_ff,   rsp_mean_in;
   logic [DEV_W-1:0]      rsp_dev_ff,    rsp_dev_in;

   logic [ROWS_W-1:0]     rows_eff;
   logic [ROWS_W-1:0]     slot;
   logic [TOT_W-1:0]      base_total;
   logic                  last_row;
   logic                  last_rd;
   logic                  req_accept;
   logic [RSUM_W-1:0]     row_sum;
   logic [WORD_W-1:0]     lo_rdata;
   logic [WORD_W-1:0]     hi_rdata;
   logic                  rd_en;
   logic                  div_start;
   logic [MEAN_W-1:0]     div_quo;
   div_status_type        div_status;
   logic [TOT_W-1:0]      dev_final;
   logic [SAT_W-1:0]      dev_wide;

   // clamp the configured row count into 1..EFF_MAX
   always_comb begin
      if (block_rows_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (block_rows_ff > ROWS_CFG_W'(EFF_MAX)) begin
         rows_eff = ROWS_W'(EFF_MAX);
      end else begin
         rows_eff = ROWS_W'(block_rows_ff);
      end
   end

   // restart a block whose count ran past the row count
   assign slot       = (cnt_ff >= rows_eff) ? '0 : cnt_ff;
   assign base_total = (cnt_ff >= rows_eff) ? '0 : total_ff;
   assign last_row   = ROWS_W'(slot + ROWS_W'(1)) == rows_eff;
   assign last_rd    = rd_cnt_ff == ROWS_W'(rows_eff - ROWS_W'(1));

   assign req_tready = (state_ff == S_FILL) && !(rsp_valid_ff && last_row);
   assign req_accept = req_tvalid && req_tready;
   assign row_sum    = RSUM_W'(word_pixel_sum(req_tdata[WORD_W-1:0]))
                     + RSUM_W'(word_pixel_sum(req_tdata[2*WORD_W-1:WORD_W]));

   // final deviation, widened for the saturation to the output width
   assign dev_final = dev_acc_ff + TOT_W'(rowdev_ff);
   assign dev_wide  = SAT_W'(dev_final);

   // row stores: low and high words of each row
   bmad_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ROWS)
   ) u_lo_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (ADDR_W'(slot)),
      .wr_data (req_tdata[WORD_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(rd_cnt_ff)),
      .rd_data (lo_rdata)
   );

   bmad_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ROWS)
   ) u_hi_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (ADDR_W'(slot)),
      .wr_data (req_tdata[2*WORD_W-1:WORD_W]),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(rd_cnt_ff)),
      .rd_data (hi_rdata)
   );

   // rounded mean: (total + 8*rows) / (16*rows)
   bmad_divider #(
      .NUM_W (TOT_W),
      .DEN_W (DIV_W)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (total_ff + TOT_W'({rows_eff, 3'b000})),
      .den    ({rows_eff, 4'b0000}),
      .quo    (div_quo),
      .status (div_status)
   );

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      block_rows_in = block_rows_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      rd_cnt_in     = rd_cnt_ff;
      dev_acc_in    = dev_acc_ff;
      mean_in       = mean_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_dev_in    = rsp_dev_ff;
      div_start     = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         S_FILL: begin
            if (req_accept) begin
               total_in = base_total + TOT_W'(row_sum);
               if (last_row) begin
                  cnt_in   = '0;
                  state_in = S_START;
               end else begin
                  cnt_in = ROWS_W'(slot + ROWS_W'(1));
               end
            end
         end
         S_START: begin
            div_start = 1'b1;
            total_in  = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               mean_in    = div_quo;
               rd_cnt_in  = '0;
               dev_acc_in = '0;
               state_in   = S_PASS;
            end
         end
         S_PASS: begin
            rd_en     = 1'b1;
            rd_cnt_in = ROWS_W'(rd_cnt_ff + ROWS_W'(1));
            if (last_rd) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // wait for the read pipeline to drain
         end
         default: begin
            state_in = S_FILL;
         end
      endcase

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate row deviations; the last one closes the block
      if (v2_ff) begin
         dev_acc_in = dev_final;
         if (last2_ff) begin
            rsp_valid_in = 1'b1;
            rsp_mean_in  = mean_ff;
            rsp_dev_in   = (dev_wide > SAT_W'({DEV_W{1'b1}})) ? {DEV_W{1'b1}}
                                                              : DEV_W'(dev_wide);
            dev_acc_in   = '0;
            state_in     = S_FILL;
         end
      end

      // register write restarts the block
      if (csr_wen) begin
         block_rows_in = csr_wdata;
         cnt_in        = '0;
         total_in      = '0;
      end
   end

   // read pipeline
   assign v1_in     = (state_ff == S_PASS);
   assign last1_in  = (state_ff == S_PASS) && last_rd;
   assign v2_in     = v1_ff;
   assign last2_in  = last1_ff;
   assign rowdev_in = RSUM_W'(word_deviation(lo_rdata, mean_ff))
                    + RSUM_W'(word_deviation(hi_rdata, mean_ff));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         block_rows_ff <= ROWS_CFG_W'(ROWS_RESET);
         cnt_ff        <= '0;
         total_ff      <= '0;
         rd_cnt_ff     <= '0;
         v1_ff         <= 1'b0;
         last1_ff      <= 1'b0;
         v2_ff         <= 1'b0;
         last2_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         block_rows_ff <= block_rows_in;
         cnt_ff        <= cnt_in;
         total_ff      <= total_in;
         rd_cnt_ff     <= rd_cnt_in;
         v1_ff         <= v1_in;
         last1_ff      <= last1_in;
         v2_ff         <= v2_in;
         last2_ff      <= last2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rowdev_ff   <= rowdev_in;
      dev_acc_ff  <= dev_acc_in;
      mean_ff     <= mean_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_dev_ff  <= rsp_dev_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dev_ff, rsp_mean_ff};

`ifndef ASSERT_OFF
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < rows_eff)
      else $error("row count reached the block row count");

   a_result_from_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FLUSH))
      else $error("result raised outside the end of the deviation pass");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIV))
      else $error("divider finished while not awaited");

   a_pass_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PASS) |=> v1_ff)
      else $error("row read issued without pipeline valid");
`endif

endmodule

// ===== test/block_mean_abs_deviation_unit_checker.sv =====
`timescale 1ns / 100ps
// Stream checker: predicts block mean and deviation results and compares them with the rsp channel.
module block_mean_abs_deviation_unit_checker #(
   parameter int MAX_ROWS = bmad_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // [63:0] row_low, [127:64] row_high
   input  logic [bmad_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] block_mean, [23:8] deviation_sum
   input  logic [bmad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wen,
   input  logic [bmad_pkg::ROWS_CFG_W-1:0]   csr_wdata,
   output int                                error_count,
   output int                                results_pending
);
   import bmad_pkg::*;

   localparam int REPORT_LIMIT = 40;

   // deviation first so that the mean lands in the low bits
   typedef struct packed {
      logic [DEV_W-1:0]  deviation;
      logic [MEAN_W-1:0] mean;
   } block_stats_type;

   logic [ROWS_CFG_W-1:0] rows_setting;
   int unsigned           rows_taken;
   int unsigned           pixel_sum;
   logic [REQ_DATA_W-1:0] stored_rows [MAX_ROWS];
   block_stats_type       stats_due [$];

   // Clamp the register value to the rows a block really has.
   function automatic int unsigned rows_in_block(input logic [ROWS_CFG_W-1:0] setting);
      if (setting == 0)
         return 1;
      if (setting > MAX_ROWS)
         return MAX_ROWS;
      return 32'(setting);
   endfunction

   function automatic int unsigned row_pixel_total(input logic [REQ_DATA_W-1:0] row);
      int unsigned total;
      total = 0;
      for (int i = 0; i < ROW_PIX; i++)
         total += 32'(row[i*PIX_W +: PIX_W]);
      return total;
   endfunction

   // Store one row; when it closes the block, queue the block's mean and deviation.
   task automatic accept_row(input logic [REQ_DATA_W-1:0] row);
      int unsigned     rows, count, mean, dev, pix;
      block_stats_type stats;
      rows = rows_in_block(rows_setting);
      if (rows_taken >= rows) begin
         rows_taken = 0;
         pixel_sum  = 0;
      end
      stored_rows[rows_taken] = row;
      pixel_sum += row_pixel_total(row);
      rows_taken++;
      if (rows_taken == rows) begin
         count = rows * ROW_PIX;
         mean  = ((pixel_sum + count / 2) / count) & 32'hFF;
         dev   = 0;
         for (int r = 0; r < rows; r++) begin
            for (int i = 0; i < ROW_PIX; i++) begin
               pix = 32'(stored_rows[r][i*PIX_W +: PIX_W]);
               dev += (pix >= mean) ? pix - mean : mean - pix;
            end
         end
         if (dev > 32'hFFFF)
            dev = 32'hFFFF;
         stats.mean      = MEAN_W'(mean);
         stats.deviation = DEV_W'(dev);
         stats_due.push_back(stats);
         rows_taken = 0;
         pixel_sum  = 0;
      end
   endtask

   task automatic flag_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      if (error_count < REPORT_LIMIT)
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      error_count++;
   endtask

   // Follow register writes, accepted rows and accepted results at each edge.
   always @(posedge clock) begin : watch
      block_stats_type seen, due;
      if (reset) begin
         rows_setting = ROWS_CFG_W'(ROWS_RESET);
         rows_taken   = 0;
         pixel_sum    = 0;
         stats_due.delete();
      end else begin
         // a write drops any partial block
         if (csr_wen) begin
            rows_setting = csr_wdata;
            rows_taken   = 0;
            pixel_sum    = 0;
         end
         if (req_tvalid && req_tready)
            accept_row(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (stats_due.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: result with none expected: block_mean %0d, deviation_sum %0d",
                           $time, seen.mean, seen.deviation);
               error_count++;
            end else begin
               due = stats_due.pop_front();
               if (seen.mean !== due.mean)
                  flag_mismatch("block_mean", 32'(due.mean), 32'(seen.mean));
               if (seen.deviation !== due.deviation)
                  flag_mismatch("deviation_sum", 32'(due.deviation), 32'(seen.deviation));
            end
         end
      end
      results_pending = stats_due.size();
   end

endmodule

// ===== test/block_mean_abs_deviation_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, row and register stimulus, and verdict for the deviation unit.
module block_mean_abs_deviation_unit_tb;
   import bmad_pkg::*;

   localparam int ITEM_TARGET   = 1650;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum {RX_OPEN, RX_SPARSE, RX_THIRD, RX_BURSTY} rx_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic [ROWS_CFG_W-1:0] csr_wdata  = '0;

   int error_count;
   int results_pending;
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;

   rx_mode_type rx_mode   = RX_OPEN;
   int          mode_left = 0;
   int          hold_left = 0;
   int          rx_cycles = 0;

   block_mean_abs_deviation_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   block_mean_abs_deviation_unit_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: switch between open, sparse, every-third and bursty stalls.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(50, 200);
      end
      mode_left--;
      rx_cycles++;
      case (rx_mode)
         RX_OPEN: begin
            rsp_tready = 1'b1;
         end
         RX_SPARSE: begin
            rsp_tready = ($urandom_range(0, 3) != 0);
         end
         RX_THIRD: begin
            rsp_tready = (rx_cycles % 3 == 0);
         end
         default: begin
            if (hold_left == 0) begin
               rsp_tready = !rsp_tready;
               hold_left  = rsp_tready ? $urandom_range(1, 4) : $urandom_range(1, 12);
            end
            hold_left--;
         end
      endcase
   end

   // Offer one row, hold it until taken, then advance the burst and sometimes idle between bursts.
   task automatic send_row(input logic [REQ_DATA_W-1:0] row);
      int gap;
      req_tdata  = row;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Hold off rows until every queued result has come out.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (results_pending != 0)
         @(negedge clock);
   endtask

   // Write the row count once the unit is idle.
   task automatic write_rows_setting(input logic [ROWS_CFG_W-1:0] setting);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wdata = setting;
      csr_wen   = 1'b1;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   // Random row: uniform noise, a narrow spread around a level, black/white, or flat.
   function automatic logic [REQ_DATA_W-1:0] random_row(input logic [PIX_W-1:0] level);
      logic [REQ_DATA_W-1:0] row;
      int                    spread, p;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            row = {$urandom, $urandom, $urandom, $urandom};
         end
         4, 5, 6: begin
            spread = $urandom_range(0, 8);
            for (int i = 0; i < ROW_PIX; i++) begin
               p = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
               if (p < 0)
                  p = 0;
               if (p > 255)
                  p = 255;
               row[i*PIX_W +: PIX_W] = PIX_W'(p);
            end
         end
         7, 8: begin
            for (int i = 0; i < ROW_PIX; i++)
               row[i*PIX_W +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: begin
            row = {ROW_PIX{level}};
         end
      endcase
      return row;
   endfunction

   initial begin : stimulus
      logic [REQ_DATA_W-1:0] row;
      logic [ROWS_CFG_W-1:0] setting;
      logic [PIX_W-1:0]      level;
      int                    rows, count, phase, pick;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setting: one block of sixteen rows
      send_row('0);
      send_row('1);
      send_row({8{8'hFF, 8'h00}});
      repeat (13) send_row({$urandom, $urandom, $urandom, $urandom});

      // one-row blocks: all black, all white, checkerboard, ramp
      write_rows_setting(ROWS_CFG_W'(1));
      send_row('0);
      send_row('1);
      send_row({8{8'h00, 8'hFF}});
      for (int i = 0; i < ROW_PIX; i++)
         row[i*PIX_W +: PIX_W] = PIX_W'(i * 17);
      send_row(row);

      // zero rows acts as one; one bright pixel, and a total that rounds up at half
      write_rows_setting(ROWS_CFG_W'(0));
      send_row({{15{8'h00}}, 8'hFF});
      send_row(128'd8);

      // partial block dropped by a register write
      write_rows_setting(ROWS_CFG_W'(3));
      send_row('1);
      send_row({$urandom, $urandom, $urandom, $urandom});
      write_rows_setting(ROWS_CFG_W'(2));
      send_row('1);
      send_row('0);

      // random phases, each with its own row count
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: setting = ROWS_CFG_W'(31);
            1: setting = ROWS_CFG_W'(17);
            2: setting = ROWS_CFG_W'(16);
            3: setting = ROWS_CFG_W'(1);
            default: begin
               pick = $urandom_range(0, 9);
               if (pick < 6)
                  setting = ROWS_CFG_W'($urandom_range(1, 4));
               else if (pick < 8)
                  setting = ROWS_CFG_W'($urandom_range(5, 16));
               else
                  setting = ROWS_CFG_W'($urandom_range(0, 31));
            end
         endcase
         rows = (setting == 0) ? 1 :
                (setting > MAX_ROWS_DEFAULT) ? MAX_ROWS_DEFAULT : int'(setting);
         count = rows * $urandom_range(1, 6);
         if ($urandom_range(0, 1))
            count += $urandom_range(0, rows - 1);
         level = PIX_W'($urandom_range(0, 255));
         write_rows_setting(setting);
         repeat (count) begin
            send_row(random_row(level));
            if ($urandom_range(0, 59) == 0)
               wait_drained();
         end
         phase++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
